/* sv/smsd_pkg.sv */
// Shared types and constants of the segment mean and deviation block.
package smsd_pkg;

   localparam int MAX_LEN     = 4096;
   localparam int SAMPLE_BITS = 16;
   localparam int MEAN_W      = 16;
   localparam int SD_W        = 15;
   localparam int COUNT_W     = $clog2(MAX_LEN + 1);
   localparam int SUM_W       = SAMPLE_BITS + COUNT_W - 1;
   localparam int SQ_W        = 2 * SAMPLE_BITS + COUNT_W - 1;
   localparam int DIV_W       = 2 * SUM_W;
   localparam int DVS_W       = COUNT_W + 1;
   localparam int JQ_DEPTH    = 2;
   localparam int JQ_PTR_W    = $clog2(JQ_DEPTH);
   localparam int JQ_CNT_W    = $clog2(JQ_DEPTH + 1);

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          has_sample;
      logic                          end_of_segment;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] mean;
      logic [SD_W-1:0]          std_dev;
      logic [COUNT_W-1:0]       sample_count;
      logic                     empty_flag;
      logic                     overflow_flag;
   } rsp_type;

   // One closed segment handed from the front end to the back end.
   typedef struct packed {
      logic signed [SUM_W-1:0] sum;
      logic [SQ_W-1:0]         sumsq;
      logic [COUNT_W-1:0]      count;
      logic                    dropped;
   } job_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] numer;
      logic [DVS_W-1:0] denom;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quot;
   } div_rsp_type;

endpackage

/* sv/segment_mean_stdev_core.sv */
// Segment mean and standard deviation: top level.
//
// Input queue side: drive req_data and raise req_push; a beat is taken at
// each edge with req_push high and req_full low. A beat may carry a sample
// (has_sample) and may close the segment (end_of_segment); the sample of
// a closing beat belongs to the segment it closes. Samples past MAX_LEN in
// one segment are dropped and reported by overflow_flag.
// The front end accumulates one beat per cycle while req_full is low. A closing beat hands the
// segment sums to a two-entry job queue; req_full is high while it is full.
// Result queue side: while rsp_empty is low, rsp_data holds the oldest
// result; rsp_pop takes it. A stalled result holds, and the back end
// waits with the next finished result until the register frees.
// A non-empty segment's result comes from the one-bit-per-cycle shared
// divider, run three times (twice when the variance clamps to zero), and
// the one-bit-per-cycle square root; an empty segment skips both. The back
// end takes a new segment only once the last result is in the result
// register. Non-closing beats go at one a cycle while req_full is low.
// Reset (synchronous) clears the accumulators, the job queue and the
// result register.
module segment_mean_stdev_core
   import smsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   logic        jq_push;
   logic        jq_full;
   job_type     jq_wdata;
   logic        jq_pop;
   logic        jq_empty;
   job_type     jq_rdata;
   div_req_type div_req;
   div_rsp_type div_rsp;

   smsd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .jq_push  (jq_push),
      .jq_full  (jq_full),
      .jq_data  (jq_wdata)
   );

   smsd_job_queue u_jq (
      .clock     (clock),
      .reset     (reset),
      .push      (jq_push),
      .push_data (jq_wdata),
      .full      (jq_full),
      .pop       (jq_pop),
      .empty     (jq_empty),
      .pop_data  (jq_rdata)
   );

   smsd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   smsd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .jq_empty  (jq_empty),
      .jq_pop    (jq_pop),
      .jq_data   (jq_rdata),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/smsd_front.sv */
// Front end: per-sample accumulation of count, sum and sum of squares.
module smsd_front
   import smsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   output logic    req_full,
   input  req_type req_data,
   output logic    jq_push,
   input  logic    jq_full,
   output job_type jq_data
);

   logic signed [SUM_W-1:0]         sum_ff, sum_in;
   logic [SQ_W-1:0]                 sumsq_ff, sumsq_in;
   logic [COUNT_W-1:0]              count_ff, count_in;
   logic                            drop_ff, drop_in;
   logic                            accept;
   logic                            take;
   logic signed [2*SAMPLE_BITS-1:0] square;

   assign req_full = jq_full;
   assign accept   = req_push && !jq_full;
   assign take     = req_data.has_sample && (count_ff < COUNT_W'(MAX_LEN));
   assign square   = req_data.sample * req_data.sample;

   always_comb begin
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      count_in = count_ff;
      drop_in  = drop_ff;
      if (take) begin
         sum_in   = sum_ff + SUM_W'(req_data.sample);
         sumsq_in = sumsq_ff + {{(SQ_W - 2*SAMPLE_BITS){1'b0}}, $unsigned(square)};
         count_in = count_ff + COUNT_W'(1);
      end else if (req_data.has_sample) begin
         drop_in = 1'b1;
      end
   end

   // The closing beat carries its own sample into the segment it closes.
   assign jq_push       = accept && req_data.end_of_segment;
   assign jq_data.sum     = sum_in;
   assign jq_data.sumsq   = sumsq_in;
   assign jq_data.count   = count_in;
   assign jq_data.dropped = drop_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else if (accept) begin
         if (req_data.end_of_segment) begin
            sum_ff   <= '0;
            sumsq_ff <= '0;
            count_ff <= '0;
            drop_ff  <= 1'b0;
         end else begin
            sum_ff   <= sum_in;
            sumsq_ff <= sumsq_in;
            count_ff <= count_in;
            drop_ff  <= drop_in;
         end
      end
   end

endmodule

/* sv/smsd_job_queue.sv */
// Short queue of closed segments between the front and back ends.
module smsd_job_queue
   import smsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output job_type pop_data
);

   job_type              entry_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0]  wr_ptr_ff;
   logic [JQ_PTR_W-1:0]  rd_ptr_ff;
   logic [JQ_CNT_W-1:0]  fill_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full     = (fill_ff == JQ_CNT_W'(JQ_DEPTH));
   assign empty    = (fill_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

/* sv/smsd_div.sv */
// Restoring divider, one quotient bit per cycle, shared by the back end.
module smsd_div
   import smsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam int DCNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0]  quo_ff;
   logic [DVS_W:0]    rem_ff;
   logic [DVS_W-1:0]  den_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DVS_W:0]    rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff[DVS_W-1:0], quo_ff[DIV_W-1]};
   assign fits   = (rem_sh >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.numer;
         rem_ff <= '0;
         den_ff <= req.denom;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
         rem_ff <= fits ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quo_ff;

endmodule

/* sv/smsd_back.sv */
// Back end: per-segment mean, variance and square root, result register.
module smsd_back
   import smsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        jq_empty,
   output logic        jq_pop,
   input  job_type     jq_data,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   localparam int RT_W      = SQ_W + 1;
   localparam int SQRT_TOP  = 2 * ((SQ_W - 1) / 2);
   localparam logic [RT_W-1:0]  SQRT_BIT0 = RT_W'(1) << SQRT_TOP;
   localparam logic [DIV_W-1:0] POS_MAX   = DIV_W'(2**(MEAN_W-1) - 1);
   localparam logic [DIV_W-1:0] NEG_MAX   = DIV_W'(2**(MEAN_W-1));
   localparam logic [RT_W-1:0]  SD_MAX    = RT_W'(2**SD_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_PROD,
      ST_TDIV,
      ST_VDIV,
      ST_SQRT,
      ST_DONE
   } state_type;

   state_type                state_ff, state_in;
   job_type                  job_ff, job_in;
   logic                     neg_ff, neg_in;
   logic [SUM_W-1:0]         mag_ff, mag_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [DIV_W-1:0]         prod_ff, prod_in;
   logic [RT_W-1:0]          rad_ff, rad_in;
   logic [RT_W-1:0]          res_ff, res_in;
   logic [RT_W-1:0]          bit_ff, bit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [DIV_W-1:0]         q_sat;
   logic [RT_W-1:0]          trial;
   logic [DIV_W-1:0]         sumsq_x;

   assign trial   = res_ff + bit_ff;
   assign sumsq_x = DIV_W'(job_ff.sumsq);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      mean_in      = mean_ff;
      prod_in      = prod_ff;
      rad_in       = rad_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      jq_pop       = 1'b0;
      div_req      = '0;
      q_sat        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!jq_empty) begin
               jq_pop = 1'b1;
               job_in = jq_data;
               neg_in = jq_data.sum[SUM_W-1];
               mag_in = jq_data.sum[SUM_W-1] ? $unsigned(-jq_data.sum)
                                             : $unsigned(jq_data.sum);
               if (jq_data.count == '0) begin
                  mean_in  = '0;
                  res_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  // Round half away from zero: (2|s| + n) / 2n.
                  div_req.start = 1'b1;
                  div_req.numer = DIV_W'({mag_in, 1'b0}) + DIV_W'(jq_data.count);
                  div_req.denom = {jq_data.count, 1'b0};
                  state_in      = ST_MEAN;
               end
            end
         end
         ST_MEAN: begin
            if (div_rsp.done) begin
               if (neg_ff) begin
                  q_sat   = (div_rsp.quot > NEG_MAX) ? NEG_MAX : div_rsp.quot;
                  mean_in = -$signed(q_sat[MEAN_W-1:0]);
               end else begin
                  q_sat   = (div_rsp.quot > POS_MAX) ? POS_MAX : div_rsp.quot;
                  mean_in = $signed(q_sat[MEAN_W-1:0]);
               end
               prod_in  = mag_ff * mag_ff;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            div_req.start = 1'b1;
            div_req.numer = prod_ff;
            div_req.denom = DVS_W'(job_ff.count);
            state_in      = ST_TDIV;
         end
         ST_TDIV: begin
            if (div_rsp.done) begin
               res_in = '0;
               bit_in = SQRT_BIT0;
               if (sumsq_x >= div_rsp.quot) begin
                  div_req.start = 1'b1;
                  div_req.numer = sumsq_x - div_rsp.quot;
                  div_req.denom = DVS_W'(job_ff.count);
                  state_in      = ST_VDIV;
               end else begin
                  // Rounding pushed the difference below zero: clamp.
                  rad_in   = '0;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_VDIV: begin
            if (div_rsp.done) begin
               rad_in   = div_rsp.quot[RT_W-1:0];
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               if (rad_ff >= trial) begin
                  rad_in = rad_ff - trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_in.mean           = mean_ff;
               rsp_in.std_dev        = (res_ff > SD_MAX) ? SD_MAX[SD_W-1:0]
                                                         : res_ff[SD_W-1:0];
               rsp_in.sample_count   = job_ff.count;
               rsp_in.empty_flag     = (job_ff.count == '0);
               rsp_in.overflow_flag  = job_ff.dropped;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff  <= job_in;
      neg_ff  <= neg_in;
      mag_ff  <= mag_in;
      mean_ff <= mean_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sv/smsd_checker.sv */
// Port-level checks of the segment mean and deviation block, with bind.
module smsd_checker
   import smsd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input logic    req_full,
   input req_type req_data,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result present right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("stalled result beat changed");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.empty_flag) |->
         (rsp_data.mean == '0 && rsp_data.std_dev == '0 && rsp_data.sample_count == '0))
      else $error("empty segment result not zero");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_data.empty_flag) |->
         (rsp_data.sample_count != '0 && rsp_data.sample_count <= COUNT_W'(MAX_LEN)))
      else $error("sample count out of range");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.overflow_flag) |->
         (rsp_data.sample_count == COUNT_W'(MAX_LEN)))
      else $error("overflow flagged on a segment that was not full");

endmodule

bind segment_mean_stdev_core smsd_checker u_smsd_checker (.*);

/* sim/testbench.sv */
// Self-checking testbench for the segment mean and standard deviation core.
module testbench;
   import smsd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STUCK_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 250;
   localparam int REPORT_CAP = 40;
   localparam int RANDOM_ITEMS = 900;

   typedef struct {
      req_type beat;
      bit      drain;
   } beat_slot;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;

   beat_slot beat_queue[$];
   rsp_type  segment_results[$];
   bit       hold_for_drain = 1'b0;
   bit       results_settled = 1'b1;

   // running statistics of the open segment
   longint          seg_sum = 0;
   longint unsigned seg_sumsq = 0;
   int              seg_count = 0;
   bit              seg_dropped = 1'b0;

   int send_gap = 0;
   int take_gap = 0;
   int take_wait = 0;
   bit send_quiet = 1'b0;
   bit take_quiet = 1'b0;
   int stuck_cycles = 0;
   int mismatch_count = 0;
   int beats_taken = 0;
   int results_checked = 0;
   int empty_results = 0;
   int overflow_results = 0;

   segment_mean_stdev_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_wait(bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 3));
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v) begin
            root = trial;
         end
      end
      return root;
   endfunction

   // Fold one beat into the segment and predict the result of a close.
   task automatic absorb_beat(req_type b);
      longint          value;
      longint unsigned n, mag, q, t, spread, sd;
      bit              neg;
      rsp_type         r;
      value = 64'(b.sample);
      if (b.has_sample) begin
         if (seg_count < MAX_LEN) begin
            seg_sum += value;
            seg_sumsq += value * value;
            seg_count++;
         end else begin
            seg_dropped = 1'b1;
         end
      end
      if (b.end_of_segment) begin
         r = '0;
         n = 64'(seg_count);
         r.sample_count = COUNT_W'(n);
         r.empty_flag = (n == 0);
         r.overflow_flag = seg_dropped;
         if (n != 0) begin
            neg = (seg_sum < 0);
            mag = neg ? -seg_sum : seg_sum;
            // round half away from zero on the magnitude
            q = (2 * mag + n) / (2 * n);
            if (neg && q > 32768) begin
               q = 32768;
            end else if (!neg && q > 32767) begin
               q = 32767;
            end
            r.mean = MEAN_W'(neg ? 0 - q : q);
            t = mag * mag / n;
            spread = (seg_sumsq >= t) ? (seg_sumsq - t) / n : 0;
            sd = floor_sqrt(spread);
            if (sd > 32767) begin
               sd = 32767;
            end
            r.std_dev = SD_W'(sd);
         end
         segment_results.push_back(r);
         seg_sum = 0;
         seg_sumsq = 0;
         seg_count = 0;
         seg_dropped = 1'b0;
      end
   endtask

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         if (mismatch_count < REPORT_CAP) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
         mismatch_count++;
      end
   endfunction

   task automatic compare_result(rsp_type want, rsp_type got);
      check_field("mean", 64'(want.mean), 64'(got.mean));
      check_field("std_dev", 64'(want.std_dev), 64'(got.std_dev));
      check_field("sample_count", 64'(want.sample_count), 64'(got.sample_count));
      check_field("empty_flag", 64'(want.empty_flag), 64'(got.empty_flag));
      check_field("overflow_flag", 64'(want.overflow_flag), 64'(got.overflow_flag));
      if (want.empty_flag) begin
         empty_results++;
      end
      if (want.overflow_flag) begin
         overflow_results++;
      end
   endtask

   function automatic void add_beat(int value, bit has, bit eos);
      beat_slot slot;
      slot.beat.sample = 16'(value);
      slot.beat.has_sample = has;
      slot.beat.end_of_segment = eos;
      slot.drain = hold_for_drain;
      hold_for_drain = 1'b0;
      beat_queue.push_back(slot);
   endfunction

   function automatic int pick_sample(int style, int centre);
      int v;
      case (style)
         0: v = $urandom_range(0, 65535);
         1: begin
            v = centre + int'($urandom_range(0, 64)) - 32;
            if (v > 32767) begin
               v = 32767;
            end else if (v < -32768) begin
               v = -32768;
            end
         end
         2: v = centre;
         default: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = -1;
               default: v = 0;
            endcase
         end
      endcase
      return v;
   endfunction

   // Sender: one beat at a time from the queue, with random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         send_gap <= 0;
      end else if (!req_push || !req_full) begin
         if (send_gap > 0) begin
            req_push <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (beat_queue.size() != 0 &&
                      (!beat_queue[0].drain || (!req_push && results_settled))) begin
            req_data <= beat_queue[0].beat;
            req_push <= 1'b1;
            void'(beat_queue.pop_front());
            send_gap <= draw_wait(send_quiet);
            if ($urandom_range(0, 49) == 0) begin
               send_quiet <= !send_quiet;
            end
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Receiver and checker: check the result side first, then predict.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         take_gap <= 0;
         results_settled <= 1'b1;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (segment_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
               mismatch_count++;
            end else begin
               compare_result(segment_results.pop_front(), rsp_data);
            end
            results_checked++;
            // a zero wait keeps pop high for the next beat
            take_wait = draw_wait(take_quiet);
            take_gap <= (take_wait > 0) ? take_wait - 1 : 0;
            rsp_pop <= (take_wait == 0);
            if ($urandom_range(0, 29) == 0) begin
               take_quiet <= !take_quiet;
            end
         end else if (take_gap > 0) begin
            take_gap <= take_gap - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
         if (req_push && !req_full) begin
            absorb_beat(req_data);
            beats_taken++;
         end
         results_settled <= (segment_results.size() == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
         $display("[segment_mean_stdev_core] ERROR");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   initial begin : stimulus
      int  produced;
      int  seg_len;
      int  kind;
      int  style;
      int  centre;
      bit  close_on_sample;

      // directed: empty segments, extremes, rounding ties, idle beats
      add_beat('h7FFF, 1'b0, 1'b1);
      add_beat(32767, 1'b1, 1'b1);
      add_beat(-32768, 1'b1, 1'b1);
      add_beat('h1234, 1'b0, 1'b0);
      add_beat(0, 1'b1, 1'b1);
      add_beat(1, 1'b1, 1'b0);
      add_beat(2, 1'b1, 1'b0);
      add_beat('hFFFF, 1'b0, 1'b1);
      add_beat(-1, 1'b1, 1'b0);
      add_beat(-2, 1'b1, 1'b1);
      add_beat(-32768, 1'b1, 1'b0);
      add_beat(32767, 1'b1, 1'b1);
      add_beat(3, 1'b1, 1'b0);
      add_beat(-3, 1'b1, 1'b0);
      add_beat(0, 1'b1, 1'b1);
      add_beat('h5A5A, 1'b0, 1'b1);
      add_beat('hA5A5, 1'b0, 1'b1);
      add_beat(100, 1'b1, 1'b0);
      add_beat(200, 1'b1, 1'b0);
      add_beat(300, 1'b1, 1'b0);
      add_beat(400, 1'b1, 1'b0);
      add_beat('h0F0F, 1'b0, 1'b1);

      // a segment of exactly MAX_LEN, then one that overruns it and closes on a
      // dropped sample, then an empty close with the dropped flag cleared
      hold_for_drain = 1'b1;
      for (int k = 0; k < MAX_LEN; k++) begin
         add_beat(-32768, 1'b1, k == MAX_LEN - 1);
      end
      for (int k = 0; k < MAX_LEN + 3; k++) begin
         add_beat((k % 2) ? 32767 : -32768, 1'b1, k == MAX_LEN + 2);
      end
      add_beat(0, 1'b0, 1'b1);

      produced = 0;
      while (produced < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         style = $urandom_range(0, 3);
         centre = int'($urandom_range(0, 65535)) - 32768;
         if (kind < 8) begin
            seg_len = 0;
         end else if (kind < 75) begin
            seg_len = $urandom_range(1, 12);
         end else if (kind < 94) begin
            seg_len = $urandom_range(13, 60);
         end else begin
            seg_len = $urandom_range(100, 400);
         end
         close_on_sample = (seg_len != 0) && ($urandom_range(0, 1) == 1);
         if ($urandom_range(0, 29) == 0) begin
            hold_for_drain = 1'b1;
         end
         for (int k = 0; k < seg_len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               add_beat($urandom_range(0, 65535), 1'b0, 1'b0);
            end
            add_beat(pick_sample(style, centre), 1'b1, close_on_sample && k == seg_len - 1);
            produced++;
         end
         if (!close_on_sample) begin
            add_beat($urandom_range(0, 65535), 1'b0, 1'b1);
            produced++;
         end
      end

      @(posedge clock);
      while (beat_queue.size() != 0 || req_push) begin
         @(posedge clock);
      end
      while (segment_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d beats and %0d segment results", beats_taken, results_checked);
      $display("(%0d empty segments, %0d with dropped samples), %0d mismatches",
               empty_results, overflow_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[segment_mean_stdev_core] OK");
      end else begin
         $display("[segment_mean_stdev_core] ERROR");
      end
      $finish;
   end

   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

endmodule

/* filelist.f */
sv/smsd_pkg.sv
sv/smsd_front.sv
sv/smsd_job_queue.sv
sv/smsd_div.sv
sv/smsd_back.sv
sv/segment_mean_stdev_core.sv
sv/smsd_checker.sv
sim/testbench.sv
